// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define MFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define MFE_NEVER(lbl, cond, msg) \
	`MFE_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/mfe_pkg.sv =====
// Package with types and constants of the Manchester frame encoder.
package mfe_pkg;

	localparam int PAYLOAD_BYTES = 64;
	localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int POS_W = 7;
	localparam logic [POS_W-1:0] SYNC_BYTES = 7'd2;
	localparam logic [POS_W-1:0] PAYLOAD_LIMIT = POS_W'(PAYLOAD_BYTES);

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	localparam logic REG_SYNC_WORD     = 1'b0;
	localparam logic REG_TICKS_PER_BIT = 1'b1;

	localparam logic [15:0] TICKS_RESET = 16'd16;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
		logic [5:0] byte_index;
		logic [7:0] frame_length;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic level_updated;
	} res_t;

	typedef struct packed {
		logic [15:0] sync_word;
		logic [15:0] ticks_per_bit;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

endpackage

// ===== design/mfe_item_if.sv =====
// Input request channel interface.
interface mfe_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] byte_value;
	logic [5:0] byte_index;
	logic [7:0] frame_length;

	modport source (output valid, action, byte_value, byte_index, frame_length, input ready);
	modport sink (input valid, action, byte_value, byte_index, frame_length, output ready);
endinterface

// ===== design/mfe_result_if.sv =====
// Result request channel interface.
interface mfe_result_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic level_updated;

	modport source (output valid, line_level, busy_res, level_updated, input ready);
	modport sink (input valid, line_level, busy_res, level_updated, output ready);
endinterface

// ===== design/mfe_cfg_if.sv =====
// Configuration write channel interface.
interface mfe_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mfe_ram.sv =====
// Generic single-port-write RAM with registered read-first read.
module mfe_ram #(
	parameter int W = 8,
	parameter int D = 64,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/mfe_store.sv =====
// Payload store: RAM, per-entry valid bits and write forwarding.
module mfe_store import mfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  store_wr_t        wr,
	input  logic [POS_W-1:0] rd_pos,
	output logic [7:0]       rd_byte
);

	logic [PAYLOAD_BYTES-1:0] vld_q;
	logic [POS_W-1:0]         off;
	logic [ADDR_W-1:0]        raddr;
	logic                     in_rng;
	logic [7:0]               ram_q;
	logic                     rng_q;
	logic                     vld_rd_q;
	logic                     fwd_q;
	logic [7:0]               fwd_data_q;

	assign off    = rd_pos - SYNC_BYTES;
	assign raddr  = ADDR_W'(off);
	assign in_rng = (rd_pos >= SYNC_BYTES) && (off < PAYLOAD_LIMIT);

	mfe_ram #(.W(8), .D(PAYLOAD_BYTES)) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rng_q    <= 1'b0;
			vld_rd_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rng_q    <= in_rng;
			vld_rd_q <= vld_q[raddr];
			fwd_q    <= wr.en && (wr.addr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr.data;
	end

	always_comb begin
		if (!rng_q) begin
			rd_byte = 8'd0;
		end else if (fwd_q) begin
			rd_byte = fwd_data_q;
		end else if (vld_rd_q) begin
			rd_byte = ram_q;
		end else begin
			rd_byte = 8'd0;
		end
	end

endmodule

// ===== design/mfe_core.sv =====
// Frame sequencer: tick counting, bit and byte positions, line level.
module mfe_core import mfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  item_t            item,
	input  cfg_t             cfg,
	input  logic [7:0]       store_byte,
	output store_wr_t        wr,
	output logic [POS_W-1:0] rd_pos,
	output res_t             res
);

	logic [15:0]      tick_q, tick_d;
	logic [2:0]       bitp_q, bitp_d;
	logic [POS_W-1:0] bytep_q, bytep_d;
	logic [POS_W-1:0] fbytes_q, fbytes_d;
	logic             half_q, half_d;
	logic             send_q, send_d;
	logic             line_q, line_d;
	logic             upd;
	logic [15:0]      half_pt;
	logic             at_half, at_full;
	logic [7:0]       cur_byte;
	logic [POS_W-1:0] len_sat;
	logic [7:0]       len_lim;

	assign half_pt = cfg.ticks_per_bit >> 1;
	assign at_full = (tick_q == cfg.ticks_per_bit);
	assign at_half = (tick_q == half_pt);
	assign len_lim = 8'(PAYLOAD_BYTES);
	assign len_sat = (item.frame_length > len_lim) ? PAYLOAD_LIMIT : POS_W'(item.frame_length);

	always_comb begin
		if (bytep_q == 7'd0) begin
			cur_byte = cfg.sync_word[7:0];
		end else if (bytep_q == 7'd1) begin
			cur_byte = cfg.sync_word[15:8];
		end else begin
			cur_byte = store_byte;
		end
	end

	always_comb begin
		tick_d   = tick_q;
		bitp_d   = bitp_q;
		bytep_d  = bytep_q;
		fbytes_d = fbytes_q;
		half_d   = half_q;
		send_d   = send_q;
		line_d   = line_q;
		upd      = 1'b0;
		wr.en    = 1'b0;
		wr.addr  = ADDR_W'(item.byte_index);
		wr.data  = item.byte_value;
		if (en) begin
			case (item.action)
				ACT_TICK: begin
					if (send_q) begin
						if (at_half || at_full) begin
							line_d = cur_byte[bitp_q] ^ half_q;
							half_d = ~half_q;
							upd    = 1'b1;
						end
						if (at_full) begin
							bitp_d = bitp_q + 3'd1;
							if (bitp_d == 3'd0) begin
								bytep_d = bytep_q + 7'd1;
								if (bytep_d == fbytes_q) begin
									send_d = 1'b0;
								end
							end
							tick_d = 16'd1;
						end else begin
							tick_d = tick_q + 16'd1;
						end
					end
				end
				ACT_WRITE: begin
					wr.en = ({1'b0, item.byte_index} < PAYLOAD_LIMIT);
				end
				ACT_START: begin
					fbytes_d = len_sat + SYNC_BYTES;
					bitp_d   = 3'd0;
					bytep_d  = 7'd0;
					tick_d   = 16'd0;
					half_d   = 1'b1;
					send_d   = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_pos            = bytep_d;
	assign res.line_level    = line_d;
	assign res.busy_res      = send_d;
	assign res.level_updated = upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= 16'd0;
			bitp_q   <= 3'd0;
			bytep_q  <= 7'd0;
			fbytes_q <= 7'd0;
			half_q   <= 1'b1;
			send_q   <= 1'b0;
			line_q   <= 1'b0;
		end else begin
			tick_q   <= tick_d;
			bitp_q   <= bitp_d;
			bytep_q  <= bytep_d;
			fbytes_q <= fbytes_d;
			half_q   <= half_d;
			send_q   <= send_d;
			line_q   <= line_d;
		end
	end

endmodule

// ===== design/manchester_frame_encoder.sv =====
// Manchester frame encoder top level: input register, sequencer, store, result register.
// A taken request is registered in the input stage, then its result in the result register.
// Throughput: one request per cycle, held back only while the result register is stalled.
// The store byte for the current frame position is read ahead from the RAM port.
// Reset (arst_n low) clears sequencer, valid flags, config and store valid bits at once;
// no clearing pass, requests are taken right after reset.
`include "assert_macros.svh"

module manchester_frame_encoder import mfe_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	mfe_cfg_if.sink      cfg,
	mfe_item_if.sink     item,
	mfe_result_if.source result
);

	cfg_t             cfg_q;
	logic             vld_s1;
	item_t            item_s1;
	logic             adv;
	logic             out_vld_q;
	res_t             out_res_q;
	res_t             core_res;
	store_wr_t        wr;
	logic [POS_W-1:0] rd_pos;
	logic [7:0]       store_byte;

	assign cfg.ready  = 1'b1;
	assign adv        = vld_s1 && (!out_vld_q || result.ready);
	assign item.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word     <= 16'd0;
			cfg_q.ticks_per_bit <= TICKS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SYNC_WORD:     cfg_q.sync_word     <= cfg.data;
				REG_TICKS_PER_BIT: cfg_q.ticks_per_bit <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.action       <= item.action;
			item_s1.byte_value   <= item.byte_value;
			item_s1.byte_index   <= item.byte_index;
			item_s1.frame_length <= item.frame_length;
		end
		if (adv) begin
			out_res_q <= core_res;
		end
	end

	mfe_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.item       (item_s1),
		.cfg        (cfg_q),
		.store_byte (store_byte),
		.wr         (wr),
		.rd_pos     (rd_pos),
		.res        (core_res)
	);

	mfe_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_pos  (rd_pos),
		.rd_byte (store_byte)
	);

	assign result.valid         = out_vld_q;
	assign result.line_level    = out_res_q.line_level;
	assign result.busy_res      = out_res_q.busy_res;
	assign result.level_updated = out_res_q.level_updated;

	`MFE_ASSERT(a_upd_only_tick, adv |=> (!out_res_q.level_updated || $past(item_s1.action) == ACT_TICK), "level update without tick")
	`MFE_ASSERT(a_start_busy, (adv && item_s1.action == ACT_START) |=> out_res_q.busy_res, "start did not set busy")
	`MFE_NEVER(a_ready_empty, !item.ready && !vld_s1, "input stalled with empty stage")

endmodule
